@@ rtl/core/i2c_slave_transaction_handler_top_assert.svh @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: assertion macros
// Clocked on clk, disabled while rst_n is low; the using module supplies both.
// ---------------------------------------------------------------------------
`ifndef I2C_SLAVE_TRANSACTION_HANDLER_TOP_ASSERT_SVH
`define I2C_SLAVE_TRANSACTION_HANDLER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define I2CST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define I2CST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/i2cst_pkg.sv @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: shared types and constants
// Function, bus command and result codes, and the per-item flag bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cst_pkg;

    typedef enum logic [2:0] {
        FUNC_BUS      = 3'd0,
        FUNC_TICK     = 3'd1,
        FUNC_APP_READ = 3'd2,
        FUNC_APP_LOAD = 3'd3,
        FUNC_ABORT    = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        CMD_NONE          = 3'd0,
        CMD_ACK           = 3'd1,
        CMD_COMPLETE      = 3'd2,
        CMD_NACK_COMPLETE = 3'd3,
        CMD_CLEAR_STOP    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        RES_UNKNOWN   = 3'd0,
        RES_OK        = 3'd1,
        RES_FAIL      = 3'd2,
        RES_ABORTED   = 3'd3,
        RES_BUS_ERROR = 3'd4,
        RES_COLLISION = 3'd5,
        RES_OVERFLOW  = 3'd6
    } res_t;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [7:0] IDLE_MAX      = 8'hFF;

    // Per-item outcome, carried alongside the store read
    typedef struct packed {
        cmd_t        cmd;
        logic        tx_valid;
        logic        rd_hit;
        logic        pending;
        logic        busy;
        res_t        result;
        logic        restarted;
        logic [5:0]  rx_count;
    } flags_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_slave_transaction_handler_top.sv @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: top level
// Slave-side transaction handling over a receive and a transmit byte store.
// ---------------------------------------------------------------------------
// Takes one item per clock unless the output stalls and returns one result per
// item, in order. Counters and flags update in the cycle an item is accepted;
// the RX and TX stores are single-port memories with a registered read, so a
// result passes the read stage, then the output register. A stalled output
// fills the read stage and then holds req_ready low. Store entries not yet
// written since reset read as zero through per-entry valid bits, so no
// clearing pass follows reset. The user must write the activity timeout
// (cfg_we/cfg_wdata) only while the block is idle, which is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module i2c_slave_transaction_handler_top
    import i2cst_pkg::*;
#(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic [2:0] func,
    input  wire logic       bus_error,
    input  wire logic       collision,
    input  wire logic       addr_stop_flag,
    input  wire logic       addr_match,
    input  wire logic       data_flag,
    input  wire logic       master_reads,
    input  wire logic       master_nack,
    input  wire logic       clock_hold,
    input  wire logic [7:0] byte_in,
    input  wire logic [4:0] buffer_index,
    input  wire logic       final_read,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic      [2:0] bus_command,
    output logic      [7:0] tx_byte,
    output logic            tx_valid,
    output logic      [7:0] read_byte,
    output logic            command_pending,
    output logic            busy_res,
    output logic      [2:0] result_code,
    output logic            restarted,
    output logic      [5:0] rx_count_out,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic             accept;
    flags_t           flags;
    logic             rx_en, rx_we;
    logic [RX_AW-1:0] rx_addr;
    logic             tx_en, tx_we;
    logic [TX_AW-1:0] tx_addr;
    logic [7:0]       rx_rdata;
    logic [7:0]       tx_rdata;

    i2cst_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH),
        .RX_AW    (RX_AW),
        .TX_AW    (TX_AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (func),
        .bus_error      (bus_error),
        .collision      (collision),
        .addr_stop_flag (addr_stop_flag),
        .addr_match     (addr_match),
        .data_flag      (data_flag),
        .master_reads   (master_reads),
        .master_nack    (master_nack),
        .clock_hold     (clock_hold),
        .buffer_index   (buffer_index),
        .final_read     (final_read),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .flags          (flags),
        .rx_en          (rx_en),
        .rx_we          (rx_we),
        .rx_addr        (rx_addr),
        .tx_en          (tx_en),
        .tx_we          (tx_we),
        .tx_addr        (tx_addr)
    );

    i2cst_store #(
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (rx_en),
        .we    (rx_we),
        .addr  (rx_addr),
        .wdata (byte_in),
        .rdata (rx_rdata)
    );

    i2cst_store #(
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_store (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (tx_en),
        .we    (tx_we),
        .addr  (tx_addr),
        .wdata (byte_in),
        .rdata (tx_rdata)
    );

    i2cst_pipe u_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .accept          (accept),
        .flags           (flags),
        .tx_rdata        (tx_rdata),
        .rx_rdata        (rx_rdata),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .bus_command     (bus_command),
        .tx_byte         (tx_byte),
        .tx_valid        (tx_valid),
        .read_byte       (read_byte),
        .command_pending (command_pending),
        .busy_res        (busy_res),
        .result_code     (result_code),
        .restarted       (restarted),
        .rx_count_out    (rx_count_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/i2cst_store.sv @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: byte store
// Single-port synchronous byte memory with registered read and per-entry
// valid bits; an entry never written since reset reads as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cst_store
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       rdata_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            else
            begin
                rvld_reg <= vld_reg[addr];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : 8'd0;

endmodule

`default_nettype wire

@@ rtl/core/i2cst_ctrl.sv @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: control
// Decodes each item, updates counters and flags, and drives the store ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_slave_transaction_handler_top_assert.svh"

module i2cst_ctrl
    import i2cst_pkg::*;
#(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32,
    parameter int RX_AW    = 5,
    parameter int TX_AW    = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [2:0]       func,
    input  wire logic             bus_error,
    input  wire logic             collision,
    input  wire logic             addr_stop_flag,
    input  wire logic             addr_match,
    input  wire logic             data_flag,
    input  wire logic             master_reads,
    input  wire logic             master_nack,
    input  wire logic             clock_hold,
    input  wire logic [4:0]       buffer_index,
    input  wire logic             final_read,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata,
    output flags_t                flags,
    output logic                  rx_en,
    output logic                  rx_we,
    output logic      [RX_AW-1:0] rx_addr,
    output logic                  tx_en,
    output logic                  tx_we,
    output logic      [TX_AW-1:0] tx_addr
);

    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic             busy_reg, busy_next;
    res_t             result_reg, result_next;
    logic             abort_reg, abort_next;
    logic             pending_reg, pending_next;
    logic [7:0]       idle_reg, idle_next;
    logic [7:0]       timeout_reg;

    logic [7:0]       idle_inc;
    logic             idx_in_rx;
    logic             idx_in_tx;
    logic             rx_room;
    logic             tx_room;
    logic             stuck;
    logic [RX_AW+4:0] idx_rx_ext;
    logic [TX_AW+4:0] idx_tx_ext;
    logic [RX_CW+5:0] rx_count_ext;
    logic             rx_rd, rx_wr, tx_rd, tx_wr;
    cmd_t             cmd;
    logic             tx_valid;
    logic             restarted;

    assign idx_in_rx  = 32'(buffer_index) < RX_DEPTH;
    assign idx_in_tx  = 32'(buffer_index) < TX_DEPTH;
    assign idx_rx_ext = {RX_AW'(0), buffer_index};
    assign idx_tx_ext = {TX_AW'(0), buffer_index};
    assign rx_room    = rx_count_reg < RX_CW'(RX_DEPTH);
    assign tx_room    = tx_count_reg < TX_CW'(TX_DEPTH);
    assign idle_inc   = (idle_reg == IDLE_MAX) ? IDLE_MAX : idle_reg + 8'd1;
    assign stuck      = data_flag | addr_stop_flag | clock_hold | collision | bus_error;

    always_comb
    begin
        rx_count_next = rx_count_reg;
        tx_count_next = tx_count_reg;
        busy_next     = busy_reg;
        result_next   = result_reg;
        abort_next    = abort_reg;
        pending_next  = pending_reg;
        idle_next     = idle_reg;
        cmd           = CMD_NONE;
        tx_valid      = 1'b0;
        restarted     = 1'b0;
        rx_rd         = 1'b0;
        rx_wr         = 1'b0;
        tx_rd         = 1'b0;
        tx_wr         = 1'b0;

        case (func_t'(func))
            FUNC_BUS:
            begin
                if (bus_error || collision)
                begin
                    rx_count_next = '0;
                    tx_count_next = '0;
                    busy_next     = 1'b0;
                    result_next   = bus_error ? RES_BUS_ERROR : RES_COLLISION;
                end
                else if (addr_stop_flag && addr_match)
                begin
                    if (abort_reg)
                    begin
                        busy_next   = 1'b0;
                        result_next = RES_ABORTED;
                        abort_next  = 1'b0;
                        cmd         = CMD_COMPLETE;
                    end
                    else if (!master_reads && pending_reg)
                    begin
                        // refuse a new write until the command is consumed
                        busy_next = 1'b0;
                        cmd       = CMD_COMPLETE;
                    end
                    else
                    begin
                        busy_next     = 1'b1;
                        result_next   = RES_UNKNOWN;
                        rx_count_next = '0;
                        tx_count_next = '0;
                        cmd           = CMD_ACK;
                    end
                    idle_next = 8'd0;
                end
                else if (addr_stop_flag)
                begin
                    busy_next   = 1'b0;
                    result_next = RES_OK;
                    if (!master_reads && (rx_count_reg != '0))
                    begin
                        pending_next = 1'b1;
                    end
                    cmd = CMD_CLEAR_STOP;
                end
                else if (data_flag)
                begin
                    if (master_reads)
                    begin
                        if ((tx_count_reg != '0) && master_nack)
                        begin
                            busy_next   = 1'b0;
                            result_next = RES_OK;
                            cmd         = CMD_COMPLETE;
                        end
                        else if (tx_room)
                        begin
                            tx_rd         = 1'b1;
                            tx_valid      = 1'b1;
                            tx_count_next = tx_count_reg + TX_CW'(1);
                            cmd           = CMD_ACK;
                        end
                        else
                        begin
                            busy_next   = 1'b0;
                            result_next = RES_OVERFLOW;
                            cmd         = CMD_COMPLETE;
                        end
                    end
                    else if (rx_room)
                    begin
                        rx_wr         = 1'b1;
                        rx_count_next = rx_count_reg + RX_CW'(1);
                        if (abort_reg)
                        begin
                            busy_next   = 1'b0;
                            result_next = RES_ABORTED;
                            abort_next  = 1'b0;
                            cmd         = CMD_COMPLETE;
                        end
                        else
                        begin
                            cmd = CMD_ACK;
                        end
                    end
                    else
                    begin
                        // drop the byte
                        busy_next   = 1'b0;
                        result_next = RES_OVERFLOW;
                        cmd         = CMD_NACK_COMPLETE;
                    end
                end
                else
                begin
                    busy_next   = 1'b0;
                    result_next = RES_FAIL;
                end
            end
            FUNC_TICK:
            begin
                idle_next = idle_inc;
                if (idle_inc > timeout_reg)
                begin
                    idle_next = 8'd0;
                    if (stuck)
                    begin
                        rx_count_next = '0;
                        tx_count_next = '0;
                        busy_next     = 1'b0;
                        result_next   = RES_UNKNOWN;
                        abort_next    = 1'b0;
                        pending_next  = 1'b0;
                        restarted     = 1'b1;
                    end
                end
            end
            FUNC_APP_READ:
            begin
                rx_rd = idx_in_rx;
                if (final_read)
                begin
                    pending_next = 1'b0;
                end
            end
            FUNC_APP_LOAD:
            begin
                tx_wr = idx_in_tx;
            end
            FUNC_ABORT:
            begin
                abort_next = 1'b1;
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase
    end

    assign rx_en   = accept && (rx_rd || rx_wr);
    assign rx_we   = rx_wr;
    assign rx_addr = rx_wr ? rx_count_reg[RX_AW-1:0] : idx_rx_ext[RX_AW-1:0];
    assign tx_en   = accept && (tx_rd || tx_wr);
    assign tx_we   = tx_wr;
    assign tx_addr = tx_wr ? idx_tx_ext[TX_AW-1:0] : tx_count_reg[TX_AW-1:0];

    assign rx_count_ext = {6'd0, rx_count_next};

    always_comb
    begin
        flags.cmd       = cmd;
        flags.tx_valid  = tx_valid;
        flags.rd_hit    = rx_rd;
        flags.pending   = pending_next;
        flags.busy      = busy_next;
        flags.result    = result_next;
        flags.restarted = restarted;
        flags.rx_count  = rx_count_ext[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            tx_count_reg <= '0;
            busy_reg     <= 1'b0;
            result_reg   <= RES_UNKNOWN;
            abort_reg    <= 1'b0;
            pending_reg  <= 1'b0;
            idle_reg     <= 8'd0;
        end
        else if (accept)
        begin
            rx_count_reg <= rx_count_next;
            tx_count_reg <= tx_count_next;
            busy_reg     <= busy_next;
            result_reg   <= result_next;
            abort_reg    <= abort_next;
            pending_reg  <= pending_next;
            idle_reg     <= idle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    `I2CST_ASSERT_IMPLY(a_busy_unknown, busy_reg, result_reg == RES_UNKNOWN, "busy with a result")
    `I2CST_ASSERT_ALWAYS(a_rx_bound, rx_count_reg <= RX_CW'(RX_DEPTH), "rx count past depth")
    `I2CST_ASSERT_ALWAYS(a_tx_bound, tx_count_reg <= TX_CW'(TX_DEPTH), "tx count past depth")

endmodule

`default_nettype wire

@@ rtl/core/i2cst_pipe.sv @@
// ---------------------------------------------------------------------------
// I2C slave transaction handler: result pipeline
// Read-return stage and output register; joins item flags with store data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_slave_transaction_handler_top_assert.svh"

module i2cst_pipe
    import i2cst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    output logic            accept,
    input  wire flags_t     flags,
    input  wire logic [7:0] tx_rdata,
    input  wire logic [7:0] rx_rdata,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic      [2:0] bus_command,
    output logic      [7:0] tx_byte,
    output logic            tx_valid,
    output logic      [7:0] read_byte,
    output logic            command_pending,
    output logic            busy_res,
    output logic      [2:0] result_code,
    output logic            restarted,
    output logic      [5:0] rx_count_out
);

    logic   s1_valid_reg, s1_valid_next;
    flags_t s1_reg;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   s1_adv;

    logic [2:0] bus_command_reg;
    logic [7:0] tx_byte_reg;
    logic       tx_valid_reg;
    logic [7:0] read_byte_reg;
    logic       pending_reg;
    logic       busy_reg;
    logic [2:0] result_reg;
    logic       restarted_reg;
    logic [5:0] rx_count_reg;

    assign s1_adv    = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
        begin
            rsp_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= flags;
        end
        if (s1_adv && s1_valid_reg)
        begin
            bus_command_reg <= s1_reg.cmd;
            tx_byte_reg     <= s1_reg.tx_valid ? tx_rdata : 8'd0;
            tx_valid_reg    <= s1_reg.tx_valid;
            read_byte_reg   <= s1_reg.rd_hit ? rx_rdata : 8'd0;
            pending_reg     <= s1_reg.pending;
            busy_reg        <= s1_reg.busy;
            result_reg      <= s1_reg.result;
            restarted_reg   <= s1_reg.restarted;
            rx_count_reg    <= s1_reg.rx_count;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign bus_command     = bus_command_reg;
    assign tx_byte         = tx_byte_reg;
    assign tx_valid        = tx_valid_reg;
    assign read_byte       = read_byte_reg;
    assign command_pending = pending_reg;
    assign busy_res        = busy_reg;
    assign result_code     = result_reg;
    assign restarted       = restarted_reg;
    assign rx_count_out    = rx_count_reg;

    `I2CST_ASSERT_IMPLY(a_stall_blocks, rsp_valid_reg && !rsp_ready && s1_valid_reg, !req_ready, "item taken into a full pipeline")
    `I2CST_ASSERT_IMPLY(a_tx_is_ack, s1_valid_reg && s1_reg.tx_valid, s1_reg.cmd == CMD_ACK && !s1_reg.rd_hit, "tx byte without ack")
    `I2CST_ASSERT_IMPLY(a_restart_quiet, s1_valid_reg && s1_reg.restarted, !s1_reg.busy && !s1_reg.pending && s1_reg.rx_count == 6'd0, "restart left driver state")

endmodule

`default_nettype wire
